/* hw/rtl/page_frame_replacement_fifo_lru_defines.svh */
// Assertion macros shared by the page frame replacement RTL.
// Both check on the rising edge of clock and are off while reset is high.
`ifndef PAGE_FRAME_REPLACEMENT_FIFO_LRU_DEFINES_SVH
`define PAGE_FRAME_REPLACEMENT_FIFO_LRU_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define PFR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/pfr_pkg.sv */
package pfr_pkg;

   // Frame store geometry
   localparam int MAX_FRAMES = 16;
   localparam int FRAME_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int COUNT_BITS = $clog2(MAX_FRAMES + 1);

   // Field widths
   localparam int VADDR_BITS = 32;
   localparam int PADDR_BITS = 35;
   localparam int SHIFT_BITS = 5;
   localparam int EVCNT_BITS = 32;
   localparam int RSP_DATA_BITS = ((PADDR_BITS + EVCNT_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 2;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLICY = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAMES = 2'd2;

   // Replacement policy codes
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU = 1'b1;

   // Control broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic [VADDR_BITS-1:0] cmp_page;
      logic [COUNT_BITS-1:0] filled;
      logic wr_en;
      logic [FRAME_BITS-1:0] wr_frame;
      logic [VADDR_BITS-1:0] wr_page;
      logic shift_en;
      logic [COUNT_BITS-1:0] shift_pos;
      logic [FRAME_BITS-1:0] find_frame;
   } cell_ctrl_type;

endpackage

/* hw/rtl/pfr_cell.sv */
module pfr_cell (
   input  logic clock,
   input  logic [pfr_pkg::FRAME_BITS-1:0] slot,
   input  pfr_pkg::cell_ctrl_type ctrl,
   input  logic [pfr_pkg::FRAME_BITS-1:0] prev_order,
   output logic [pfr_pkg::FRAME_BITS-1:0] order,
   output logic page_match,
   output logic order_match
);

   logic [pfr_pkg::VADDR_BITS-1:0] page_ff;
   logic [pfr_pkg::VADDR_BITS-1:0] page_in;
   logic [pfr_pkg::FRAME_BITS-1:0] order_ff;
   logic [pfr_pkg::FRAME_BITS-1:0] order_in;
   logic active;

   // Slot takes part only once filled
   assign active = pfr_pkg::COUNT_BITS'(slot) < ctrl.filled;

   // Compare held page and recency entry against the broadcast keys
   assign page_match = active && (page_ff == ctrl.cmp_page);
   assign order_match = active && (order_ff == ctrl.find_frame);
   assign order = order_ff;

   // Load a new page when this frame is written
   always_comb begin
      page_in = page_ff;
      if (ctrl.wr_en && (ctrl.wr_frame == slot)) begin
         page_in = ctrl.wr_page;
      end
   end

   // Take the neighbor's recency entry when the shift covers this slot
   always_comb begin
      order_in = order_ff;
      if (ctrl.shift_en && (pfr_pkg::COUNT_BITS'(slot) <= ctrl.shift_pos)) begin
         order_in = prev_order;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      order_ff <= order_in;
   end

endmodule

/* hw/rtl/pfr_first.sv */
module pfr_first (
   input  logic [pfr_pkg::MAX_FRAMES-1:0] hits,
   output logic found,
   output logic [pfr_pkg::FRAME_BITS-1:0] index
);

   // Pick the lowest set position
   always_comb begin
      index = '0;
      for (int i = pfr_pkg::MAX_FRAMES - 1; i >= 0; i--) begin
         if (hits[i]) begin
            index = pfr_pkg::FRAME_BITS'(i);
         end
      end
   end

   assign found = |hits;

endmodule

/* hw/rtl/page_frame_replacement_fifo_lru.sv */
// Page frame replacement with FIFO or LRU victim choice.
// The req channel carries a virtual byte address; the rsp channel returns the
// physical address (frame shifted by the page size plus the page offset), the
// running eviction count, and hit / evicted flags in rsp_tuser.
// The csr channel writes policy, page shift and frame count; it is always
// ready and is meant to be written only while no access is in flight.
// Each access is a compare followed by an update: in the accept cycle the page
// is compared against all frame cells in parallel; in the busy state that
// follows, the frame store and the recency chain are updated and the result is
// loaded into the output register. No new request is accepted until the busy
// state has finished its update; rsp_tvalid rises when the output register is
// loaded. The output register lets the next access be accepted while a result
// waits; if that waiting result is still not taken when the next one is ready,
// the update holds and req_tready stays low until rsp_tready returns.
// Reset empties the frame store, clears the FIFO pointer and eviction count
// and restores the default registers (FIFO, 4 KiB pages, all frames).
module page_frame_replacement_fifo_lru (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [31:0] virtual_address
   input  logic [pfr_pkg::VADDR_BITS-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [34:0] physical_address, [66:35] eviction_total, [71:67] zero
   output logic [pfr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] page_hit, [1] page_evicted
   output logic [pfr_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [pfr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pfr_pkg::CSR_DATA_BITS-1:0] csr_data
);

`include "page_frame_replacement_fifo_lru_defines.svh"

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   localparam int FB = pfr_pkg::FRAME_BITS;
   localparam int CB = pfr_pkg::COUNT_BITS;
   localparam int VB = pfr_pkg::VADDR_BITS;
   localparam int PB = pfr_pkg::PADDR_BITS;
   localparam int EB = pfr_pkg::EVCNT_BITS;
   localparam int SB = pfr_pkg::SHIFT_BITS;

   // Configuration registers
   logic policy_ff, policy_in;
   logic [SB-1:0] shift_ff, shift_in;
   logic [pfr_pkg::CSR_DATA_BITS-1:0] frames_ff, frames_in;

   // Control state
   state_type state_ff, state_in;
   logic [CB-1:0] filled_ff, filled_in;
   logic [FB-1:0] fifo_ff, fifo_in;
   logic [EB-1:0] eviction_ff, eviction_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Per-access payload
   logic hit_ff, hit_in;
   logic [FB-1:0] hframe_ff, hframe_in;
   logic [VB-1:0] page_ff, page_in;
   logic [VB-1:0] offset_ff, offset_in;
   logic [pfr_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [pfr_pkg::RSP_USER_BITS-1:0] rsp_user_ff, rsp_user_in;

   // Chain signals
   pfr_pkg::cell_ctrl_type ctrl;
   logic [pfr_pkg::MAX_FRAMES-1:0] page_hits;
   logic [pfr_pkg::MAX_FRAMES-1:0] order_hits;
   logic [FB-1:0] order_vec [pfr_pkg::MAX_FRAMES];
   logic [FB-1:0] prev_vec [pfr_pkg::MAX_FRAMES];

   logic req_xfer, do_update;
   logic [VB-1:0] req_page, req_offset;
   logic look_hit, order_found;
   logic [FB-1:0] look_frame, order_pos;
   logic [CB-1:0] usable;
   logic [FB-1:0] last_idx, rd_idx, order_rd, fifo_pick;
   logic [CB-1:0] fifo_step;
   logic [FB-1:0] frame;
   logic [FB-1:0] front;
   logic shift_en, fill, evict;
   logic [CB-1:0] shift_pos;
   logic [PB-1:0] paddr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer = req_tvalid && req_tready;
   assign do_update = (state_ff == ST_BUSY) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready = 1'b1;

   // Split the address into page and offset
   assign req_page = req_tdata >> shift_ff;
   assign req_offset = req_tdata & ~({VB{1'b1}} << shift_ff);

   // Frame cells; the head of the recency chain takes the front entry
   for (genvar g = 0; g < pfr_pkg::MAX_FRAMES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_vec[g] = front;
      end else begin : g_link
         assign prev_vec[g] = order_vec[g-1];
      end
      pfr_cell u_cell (
         .clock       (clock),
         .slot        (FB'(g)),
         .ctrl        (ctrl),
         .prev_order  (prev_vec[g]),
         .order       (order_vec[g]),
         .page_match  (page_hits[g]),
         .order_match (order_hits[g])
      );
   end

   pfr_first u_page_first (
      .hits  (page_hits),
      .found (look_hit),
      .index (look_frame)
   );

   pfr_first u_order_first (
      .hits  (order_hits),
      .found (order_found),
      .index (order_pos)
   );

   // Clamp the frame count to the range from one to the store size
   always_comb begin
      if (frames_ff == '0) begin
         usable = CB'(1);
      end else if (int'(frames_ff) > pfr_pkg::MAX_FRAMES) begin
         usable = CB'(pfr_pkg::MAX_FRAMES);
      end else begin
         usable = CB'(frames_ff);
      end
   end

   // Victim candidates and the recency entry to bring forward
   assign last_idx = FB'(filled_ff - CB'(1));
   assign rd_idx = hit_ff ? (order_found ? order_pos : '0) : last_idx;
   assign order_rd = order_vec[rd_idx];
   assign fifo_pick = (CB'(fifo_ff) >= filled_ff) ? '0 : fifo_ff;
   assign fifo_step = CB'(fifo_pick) + CB'(1);

   // Decide hit, fill or eviction for the pending access
   always_comb begin
      frame = hframe_ff;
      front = order_rd;
      shift_en = 1'b0;
      shift_pos = '0;
      fill = 1'b0;
      evict = 1'b0;
      if (hit_ff) begin
         if (policy_ff == pfr_pkg::POLICY_LRU) begin
            shift_en = 1'b1;
            shift_pos = order_found ? CB'(order_pos) : '0;
         end
      end else if (filled_ff < usable) begin
         fill = 1'b1;
         frame = FB'(filled_ff);
         front = FB'(filled_ff);
         shift_en = 1'b1;
         shift_pos = filled_ff;
      end else if (filled_ff != '0) begin
         evict = 1'b1;
         if (policy_ff == pfr_pkg::POLICY_LRU) begin
            frame = order_rd;
            shift_en = 1'b1;
            shift_pos = filled_ff - CB'(1);
         end else begin
            frame = fifo_pick;
         end
      end
   end

   // Broadcast to the chain
   always_comb begin
      ctrl.cmp_page = req_page;
      ctrl.filled = filled_ff;
      ctrl.wr_en = do_update && (fill || evict);
      ctrl.wr_frame = frame;
      ctrl.wr_page = page_ff;
      ctrl.shift_en = do_update && shift_en;
      ctrl.shift_pos = shift_pos;
      ctrl.find_frame = hframe_ff;
   end

   assign paddr = (PB'(frame) << shift_ff) | PB'(offset_ff);

   // Configuration writes
   always_comb begin
      policy_in = policy_ff;
      shift_in = shift_ff;
      frames_in = frames_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pfr_pkg::CSR_POLICY: policy_in = csr_data[0];
            pfr_pkg::CSR_SHIFT:  shift_in = csr_data[SB-1:0];
            pfr_pkg::CSR_FRAMES: frames_in = csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer, counters and output register
   always_comb begin
      state_in = state_ff;
      filled_in = filled_ff;
      fifo_in = fifo_ff;
      eviction_in = eviction_ff;
      rsp_valid_in = rsp_valid_ff;
      hit_in = hit_ff;
      hframe_in = hframe_ff;
      page_in = page_ff;
      offset_in = offset_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               hit_in = look_hit;
               hframe_in = look_frame;
               page_in = req_page;
               offset_in = req_offset;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (do_update) begin
               if (fill) begin
                  filled_in = filled_ff + CB'(1);
               end
               if (evict) begin
                  eviction_in = eviction_ff + EB'(1);
                  if (policy_ff == pfr_pkg::POLICY_FIFO) begin
                     fifo_in = (fifo_step >= filled_ff) ? '0 : FB'(fifo_step);
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in = pfr_pkg::RSP_DATA_BITS'({eviction_in, paddr});
               rsp_user_in = {evict, hit_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         filled_ff <= '0;
         fifo_ff <= '0;
         eviction_ff <= '0;
         rsp_valid_ff <= 1'b0;
         policy_ff <= pfr_pkg::POLICY_FIFO;
         shift_ff <= SB'(12);
         frames_ff <= pfr_pkg::CSR_DATA_BITS'(16);
      end else begin
         state_ff <= state_in;
         filled_ff <= filled_in;
         fifo_ff <= fifo_in;
         eviction_ff <= eviction_in;
         rsp_valid_ff <= rsp_valid_in;
         policy_ff <= policy_in;
         shift_ff <= shift_in;
         frames_ff <= frames_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      hframe_ff <= hframe_in;
      page_ff <= page_in;
      offset_ff <= offset_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   // Checks
   `PFR_ASSERT_NEXT(a_accept_to_busy, req_xfer, state_ff == ST_BUSY,
      "accept did not start update")
   `PFR_ASSERT_NEXT(a_evict_counts, do_update && evict,
      eviction_ff == EB'($past(eviction_ff) + EB'(1)), "eviction not counted")
   `PFR_ASSERT_IMPL(a_fifo_in_range, filled_ff != '0, CB'(fifo_ff) < filled_ff,
      "fifo pointer beyond filled frames")
   `PFR_ASSERT_IMPL(a_hit_no_evict, rsp_valid_ff, !(rsp_user_ff[0] && rsp_user_ff[1]),
      "hit and eviction together")

endmodule

/* test/page_frame_replacement_fifo_lru_tb.sv */
`timescale 1ns / 100ps

module page_frame_replacement_fifo_lru_tb;

   localparam int VADDR_BITS = pfr_pkg::VADDR_BITS;
   localparam int PADDR_BITS = pfr_pkg::PADDR_BITS;
   localparam int EVCNT_BITS = pfr_pkg::EVCNT_BITS;
   localparam int SHIFT_BITS = pfr_pkg::SHIFT_BITS;
   localparam int MAX_FRAMES = pfr_pkg::MAX_FRAMES;
   localparam int FRAME_BITS = pfr_pkg::FRAME_BITS;
   localparam int CSR_INDEX_BITS = pfr_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS = pfr_pkg::CSR_DATA_BITS;
   localparam int RSP_DATA_BITS = pfr_pkg::RSP_DATA_BITS;
   localparam int RSP_USER_BITS = pfr_pkg::RSP_USER_BITS;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int DIRECTED_ROWS = 25;
   localparam int PHASE_SEGMENTS = 6;
   localparam int SEGMENT_LOOKUPS = 90;
   localparam int POOL_PAGES = 20;
   localparam int unsigned RING_DEPTH = 8;

   // One translation as it leaves the block
   typedef struct packed {
      logic [PADDR_BITS-1:0] physical_address;
      logic page_hit;
      logic page_evicted;
      logic [EVCNT_BITS-1:0] eviction_total;
   } xlate_result_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_PREDICT,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0] reg_data;
      logic [VADDR_BITS-1:0] vaddr;
      xlate_result_type result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [VADDR_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = pfr_pkg::CSR_POLICY;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;

   // Translations waiting for their result transfer, oldest at ring_rd
   xlate_result_type result_ring [RING_DEPTH];
   int unsigned ring_wr = 0;
   int unsigned ring_rd = 0;

   // Shadow copy of the block's registers and frame store
   logic cfg_policy;
   logic [SHIFT_BITS-1:0] cfg_shift;
   logic [CSR_DATA_BITS-1:0] cfg_frames;
   logic [VADDR_BITS-1:0] page_of_frame [MAX_FRAMES];
   logic [FRAME_BITS-1:0] recency [MAX_FRAMES];
   int unsigned filled;
   int unsigned fifo_next;
   logic [EVCNT_BITS-1:0] evictions;

   page_frame_replacement_fifo_lru i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Move the recency entry at pos to the front, shifting the others back
   function automatic void move_to_front(int unsigned pos);
      logic [FRAME_BITS-1:0] f;
      f = recency[pos];
      for (int k = pos; k > 0; k--) begin
         recency[k] = recency[k-1];
      end
      recency[0] = f;
   endfunction

   // Look up one address, update the shadow store and return the translation
   function automatic xlate_result_type translate_access(logic [VADDR_BITS-1:0] vaddr);
      logic [VADDR_BITS-1:0] page;
      logic [63:0] offset;
      logic [63:0] wide;
      int unsigned frame;
      int unsigned limit;
      int unsigned pos;
      bit hit;
      bit evicted;
      xlate_result_type r;
      page = vaddr >> cfg_shift;
      offset = {32'b0, vaddr} & ((64'd1 << cfg_shift) - 64'd1);
      frame = 0;
      hit = 1'b0;
      evicted = 1'b0;
      for (int unsigned i = 0; i < filled; i++) begin
         if (!hit && page_of_frame[i] == page) begin
            hit = 1'b1;
            frame = i;
         end
      end
      // Out-of-range frame counts clamp to 1..MAX_FRAMES
      if (cfg_frames == 0) limit = 1;
      else if (cfg_frames > MAX_FRAMES) limit = MAX_FRAMES;
      else limit = cfg_frames;

      if (hit) begin
         if (cfg_policy == pfr_pkg::POLICY_LRU) begin
            pos = 0;
            for (int j = filled - 1; j >= 0; j--) begin
               if (recency[j] == frame[FRAME_BITS-1:0]) pos = j;
            end
            move_to_front(pos);
         end
      end else if (filled < limit) begin
         // Fill the next free frame; it becomes most recent
         frame = filled;
         page_of_frame[frame] = page;
         filled++;
         recency[filled-1] = frame[FRAME_BITS-1:0];
         move_to_front(filled - 1);
      end else if (filled > 0) begin
         // Replace a victim among all filled frames
         if (cfg_policy == pfr_pkg::POLICY_LRU) begin
            frame = recency[filled-1];
            move_to_front(filled - 1);
         end else begin
            if (fifo_next >= filled) fifo_next = 0;
            frame = fifo_next;
            fifo_next = (fifo_next + 1 >= filled) ? 0 : fifo_next + 1;
         end
         page_of_frame[frame] = page;
         evictions++;
         evicted = 1'b1;
      end

      wide = (64'(frame) << cfg_shift) + offset;
      r.physical_address = wide[PADDR_BITS-1:0];
      r.page_hit = hit;
      r.page_evicted = evicted;
      r.eviction_total = evictions;
      return r;
   endfunction

   function automatic stim_row_type write_row(logic [CSR_INDEX_BITS-1:0] idx,
                                              logic [CSR_DATA_BITS-1:0] data);
      stim_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.reg_index = idx;
      r.reg_data = data;
      return r;
   endfunction

   function automatic stim_row_type access_row(logic [VADDR_BITS-1:0] vaddr);
      stim_row_type r;
      r = '0;
      r.kind = ROW_PREDICT;
      r.vaddr = vaddr;
      return r;
   endfunction

   function automatic stim_row_type typed_row(logic [VADDR_BITS-1:0] vaddr,
                                              logic [PADDR_BITS-1:0] paddr, bit hit,
                                              bit evicted, logic [EVCNT_BITS-1:0] total);
      stim_row_type r;
      r = '0;
      r.kind = ROW_TYPED;
      r.vaddr = vaddr;
      r.result = '{paddr, hit, evicted, total};
      return r;
   endfunction

   // Compare each result transfer with the oldest pending translation
   always @(posedge clock) begin : check_results
      xlate_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ring_rd == ring_wr) begin
            $error("result with no pending translation: physical_address 0x%0h",
                   rsp_tdata[PADDR_BITS-1:0]);
            mismatch_count++;
         end else begin
            want = result_ring[ring_rd % RING_DEPTH];
            ring_rd++;
            if (rsp_tdata[PADDR_BITS-1:0] !== want.physical_address) begin
               $error("physical_address: expected 0x%0h, actual 0x%0h",
                      want.physical_address, rsp_tdata[PADDR_BITS-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== want.page_hit) begin
               $error("page_hit: expected %0b, actual %0b", want.page_hit, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== want.page_evicted) begin
               $error("page_evicted: expected %0b, actual %0b",
                      want.page_evicted, rsp_tuser[1]);
               mismatch_count++;
            end
            if (rsp_tdata[PADDR_BITS+EVCNT_BITS-1:PADDR_BITS] !== want.eviction_total) begin
               $error("eviction_total: expected %0d, actual %0d", want.eviction_total,
                      rsp_tdata[PADDR_BITS+EVCNT_BITS-1:PADDR_BITS]);
               mismatch_count++;
            end
         end
      end
   end

   // Drop the request and hold until every pending translation has returned
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (ring_wr != ring_rd) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register once the block is idle
   task automatic program_register(logic [CSR_INDEX_BITS-1:0] idx,
                                   logic [CSR_DATA_BITS-1:0] data);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         pfr_pkg::CSR_POLICY: cfg_policy = data[0];
         pfr_pkg::CSR_SHIFT: cfg_shift = data;
         pfr_pkg::CSR_FRAMES: cfg_frames = data;
         default: ;
      endcase
   endtask

   // Transfer one address, record its translation, then idle at random
   task automatic issue_lookup(logic [VADDR_BITS-1:0] vaddr, bit typed,
                               xlate_result_type typed_result);
      xlate_result_type predicted;
      req_tvalid <= 1'b1;
      req_tdata <= vaddr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = translate_access(vaddr);
      if (ring_wr - ring_rd >= RING_DEPTH) begin
         $error("translations pending: expected below %0d, actual %0d",
                RING_DEPTH, ring_wr - ring_rd);
         mismatch_count++;
      end
      result_ring[ring_wr % RING_DEPTH] = typed ? typed_result : predicted;
      ring_wr++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= $urandom;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   initial begin : run_test
      stim_row_type directed [DIRECTED_ROWS];
      logic [VADDR_BITS-1:0] page_pool [POOL_PAGES];
      logic [VADDR_BITS-1:0] vaddr;
      int unsigned pool_span;

      // Shadow state after reset
      cfg_policy = pfr_pkg::POLICY_FIFO;
      cfg_shift = 5'd12;
      cfg_frames = 5'd16;
      filled = 0;
      fifo_next = 0;
      evictions = '0;
      foreach (page_of_frame[i]) page_of_frame[i] = '0;
      foreach (recency[i]) recency[i] = '0;

      directed = '{
         // A frame count of zero acts as one frame
         write_row(pfr_pkg::CSR_FRAMES, 5'd0),
         typed_row(32'h0000_0000, 35'h0, 1'b0, 1'b0, 32'd0),
         typed_row(32'h0000_0FFF, 35'hFFF, 1'b1, 1'b0, 32'd0),
         typed_row(32'hFFFF_FFFF, 35'hFFF, 1'b0, 1'b1, 32'd1),
         write_row(pfr_pkg::CSR_FRAMES, 5'd2),
         typed_row(32'h0000_1234, 35'h1234, 1'b0, 1'b0, 32'd1),
         typed_row(32'hFFFF_F000, 35'h0, 1'b1, 1'b0, 32'd1),
         typed_row(32'h0000_2000, 35'h0, 1'b0, 1'b1, 32'd2),
         // Switch to LRU with a recency order built under FIFO
         write_row(pfr_pkg::CSR_POLICY, 5'(pfr_pkg::POLICY_LRU)),
         access_row(32'h0000_1000),
         access_row(32'h0000_3000),
         access_row(32'h0000_1ABC),
         access_row(32'h0000_4000),
         // Largest page size
         write_row(pfr_pkg::CSR_SHIFT, 5'd31),
         access_row(32'h8000_0000),
         access_row(32'h7FFF_FFFF),
         access_row(32'hFFFF_FFFF),
         // Byte pages, frame count above the maximum, back to FIFO
         write_row(pfr_pkg::CSR_SHIFT, 5'd0),
         write_row(pfr_pkg::CSR_FRAMES, 5'd31),
         write_row(pfr_pkg::CSR_POLICY, 5'(pfr_pkg::POLICY_FIFO)),
         access_row(32'h0000_0001),
         access_row(32'hFFFF_FFFF),
         access_row(32'h0000_0001),
         write_row(pfr_pkg::CSR_SHIFT, 5'd12),
         access_row(32'h5A5A_5000)
      };

      send_idle_pct = 19;
      recv_idle_pct <= 48;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      foreach (directed[r]) begin
         case (directed[r].kind)
            ROW_WRITE: program_register(directed[r].reg_index, directed[r].reg_data);
            ROW_TYPED: issue_lookup(directed[r].vaddr, 1'b1, directed[r].result);
            default: issue_lookup(directed[r].vaddr, 1'b0, '0);
         endcase
      end

      // Random lookups over a small page pool, three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct <= 48;
            end
            1: begin
               send_idle_pct = 48;
               recv_idle_pct <= 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (int seg = 0; seg < PHASE_SEGMENTS; seg++) begin
            program_register(pfr_pkg::CSR_POLICY, 5'($urandom));
            case ($urandom_range(4))
               0: program_register(pfr_pkg::CSR_SHIFT, 5'd0);
               1: program_register(pfr_pkg::CSR_SHIFT, 5'd31);
               2: program_register(pfr_pkg::CSR_SHIFT, 5'd12);
               default: program_register(pfr_pkg::CSR_SHIFT, 5'($urandom));
            endcase
            case ($urandom_range(5))
               0: program_register(pfr_pkg::CSR_FRAMES, 5'd0);
               1: program_register(pfr_pkg::CSR_FRAMES, 5'd1);
               2: program_register(pfr_pkg::CSR_FRAMES, 5'd16);
               3: program_register(pfr_pkg::CSR_FRAMES, 5'd31);
               default: program_register(pfr_pkg::CSR_FRAMES, 5'($urandom));
            endcase
            foreach (page_pool[k]) page_pool[k] = $urandom;
            pool_span = $urandom_range(POOL_PAGES - 1, 3);
            for (int n = 0; n < SEGMENT_LOOKUPS; n++) begin
               if ($urandom_range(99) < 12) begin
                  vaddr = $urandom;
               end else begin
                  vaddr = (page_pool[$urandom_range(pool_span)] << cfg_shift)
                        | ($urandom & ~(32'hFFFF_FFFF << cfg_shift));
               end
               issue_lookup(vaddr, 1'b0, '0);
            end
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_cell.sv
hw/rtl/pfr_first.sv
hw/rtl/page_frame_replacement_fifo_lru.sv
test/page_frame_replacement_fifo_lru_tb.sv
